// ----- sv/ppurv_pkg.sv -----
package ppurv_pkg;

  // Store sizes
  localparam int unsigned NT_BYTES  = 1024;
  localparam int unsigned PAT_BYTES = 8192;
  localparam int unsigned OAM_BYTES = 256;
  localparam int unsigned PAL_BYTES = 32;

  localparam int unsigned NT_AW  = $clog2(2 * NT_BYTES);
  localparam int unsigned PAT_AW = $clog2(PAT_BYTES);
  localparam int unsigned OAM_AW = $clog2(OAM_BYTES);
  localparam int unsigned PAL_AW = $clog2(PAL_BYTES);

  // Register numbers on the CPU side
  localparam logic [2:0] REG_CTRL    = 3'd0;
  localparam logic [2:0] REG_MASK    = 3'd1;
  localparam logic [2:0] REG_STATUS  = 3'd2;
  localparam logic [2:0] REG_OAMADDR = 3'd3;
  localparam logic [2:0] REG_OAMDATA = 3'd4;
  localparam logic [2:0] REG_SCROLL  = 3'd5;
  localparam logic [2:0] REG_ADDR    = 3'd6;
  localparam logic [2:0] REG_DATA    = 3'd7;

  // Access kinds
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Mirroring modes
  localparam logic [1:0] MIRROR_VERT = 2'd0;
  localparam logic [1:0] MIRROR_HORZ = 2'd1;

  // Video address map and palette masks
  localparam logic [13:0] PAL_BASE   = 14'h3F00;
  localparam logic [7:0]  GRAY_MASK  = 8'h30;
  localparam logic [7:0]  COLOR_MASK = 8'h3F;
  localparam logic [15:0] STEP_ONE   = 16'd1;
  localparam logic [15:0] STEP_ROW   = 16'd32;

endpackage

// ----- sv/ppurv_in_if.sv -----
interface ppurv_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [2:0] reg_index;
  logic [7:0] write_data;
  logic [2:0] render_status;

  modport source (output valid, action, reg_index, write_data, render_status, input ready);
  modport sink (input valid, action, reg_index, write_data, render_status, output ready);
endinterface

// ----- sv/ppurv_out_if.sv -----
interface ppurv_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        clear_vblank;
  logic [7:0]  ctrl_value;
  logic [7:0]  mask_value;
  logic [15:0] current_address;
  logic [15:0] scroll_temp;
  logic [2:0]  fine_scroll_x;

  modport source (output valid, read_data, clear_vblank, ctrl_value, mask_value,
                  current_address, scroll_temp, fine_scroll_x, input ready);
  modport sink (input valid, read_data, clear_vblank, ctrl_value, mask_value,
                current_address, scroll_temp, fine_scroll_x, output ready);
endinterface

// ----- sv/ppurv_ram.sv -----
module ppurv_ram #(
  parameter int unsigned AW = 8,
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  // Single port; the read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/ppu_register_vram_port.sv -----
// Picture-unit register port with its video memories.
// Channels: req_i carries one CPU bus access (action, reg_index, write_data,
// render_status); rsp_o returns one beat per access with the read byte, the
// vblank clear request and the control, mask, scroll and address registers
// as they stand after the access. The APB port holds the mirroring mode at
// byte addresses 0 to 3; pready is always high and a write takes setup and access.
// Each access has an accepting cycle, which reads pattern, name-table,
// palette and OAM RAM at the current video address and OAM index, and an
// execute step, which updates the registers, writes back to at most one RAM
// and loads the output register; a busy output register holds the execute
// step. A new access is taken only after the execute step completes, as the
// read and the write-back share the single port of each RAM.
// The result beat is offered in the cycle after the update.
// After reset a clearing pass zeroes pattern, name-table, OAM and palette
// RAM, one address a cycle across the pattern address range; no access is taken meanwhile.
// When the receiver stalls, one finished result waits in the output
// register while the next access is accepted and read; that access then
// holds until the output register is free.
module ppu_register_vram_port (
  input  logic        clk_i,
  input  logic        rst_ni,
  ppurv_in_if.sink    req_i,
  ppurv_out_if.source rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC} state_e;

  state_e      state_q, state_d;
  logic [ppurv_pkg::PAT_AW-1:0] clr_cnt_q, clr_cnt_d;
  logic [1:0]  mirror_q;

  // Captured access
  logic        act_q;
  logic [2:0]  reg_q;
  logic [7:0]  wdata_q;
  logic [2:0]  rs_q;

  // Architectural registers
  logic [7:0]  ctrl_q, ctrl_d;
  logic [7:0]  mask_q, mask_d;
  logic        toggle_q, toggle_d;
  logic [7:0]  rbuf_q, rbuf_d;
  logic [15:0] vaddr_q, vaddr_d;
  logic [15:0] taddr_q, taddr_d;
  logic [2:0]  finex_q, finex_d;
  logic [7:0]  oam_idx_q, oam_idx_d;

  // Output register
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_data_q, out_data_d;
  logic        out_clr_q, out_clr_d;

  logic        accept, complete, clearing;
  logic        data_wr;

  // Address decode of the current video address
  logic [13:0] va14;
  logic        is_pat, is_pal, nt_hit, nt_table;
  logic [ppurv_pkg::NT_AW-1:0]  nt_addr;
  logic [ppurv_pkg::PAL_AW-1:0] pal_addr;
  logic [7:0]  mem_val;

  // RAM ports
  logic        pat_en, pat_we, nt_en, nt_we, pal_en, pal_we, oam_en, oam_we;
  logic [ppurv_pkg::PAT_AW-1:0] pat_a;
  logic [ppurv_pkg::NT_AW-1:0]  nt_a;
  logic [ppurv_pkg::PAL_AW-1:0] pal_a;
  logic [ppurv_pkg::OAM_AW-1:0] oam_a;
  logic [7:0]  ram_wdata;
  logic [7:0]  pat_rdata, nt_rdata, pal_rdata, oam_rdata;

  assign clearing = (state_q == ST_CLEAR);
  assign req_i.ready = (state_q == ST_IDLE);
  assign accept = req_i.valid && req_i.ready;
  assign complete = (state_q == ST_EXEC) && (!out_valid_q || rsp_o.ready);

  // Configuration port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {30'd0, mirror_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mirror_q <= ppurv_pkg::MIRROR_VERT;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      mirror_q <= pwdata[1:0];
    end
  end

  // Video address decode
  assign va14     = vaddr_q[13:0];
  assign is_pat   = !va14[13];
  assign is_pal   = (va14 >= ppurv_pkg::PAL_BASE);
  assign nt_hit   = (mirror_q == ppurv_pkg::MIRROR_VERT) ||
                    (mirror_q == ppurv_pkg::MIRROR_HORZ);
  assign nt_table = (mirror_q == ppurv_pkg::MIRROR_VERT) ? va14[10] : va14[11];
  assign nt_addr  = {nt_table, va14[9:0]};
  // Entries 0x10, 0x14, 0x18 and 0x1C alias the backdrop entries below them.
  assign pal_addr = (va14[4] && (va14[1:0] == 2'b00)) ? {1'b0, va14[3:0]} : va14[4:0];

  always_comb begin
    if (is_pat) begin
      mem_val = pat_rdata;
    end else if (is_pal) begin
      mem_val = pal_rdata & (mask_q[0] ? ppurv_pkg::GRAY_MASK : ppurv_pkg::COLOR_MASK);
    end else begin
      mem_val = nt_hit ? nt_rdata : 8'd0;
    end
  end

  // RAM control: clearing pass, read on accept, write back on completion
  assign data_wr = complete && (act_q == ppurv_pkg::ACT_WRITE) && (reg_q == ppurv_pkg::REG_DATA);

  assign pat_we = clearing || (data_wr && is_pat);
  assign nt_we  = clearing || (data_wr && !is_pat && !is_pal && nt_hit);
  assign pal_we = clearing || (data_wr && is_pal);
  assign oam_we = clearing || (complete && (act_q == ppurv_pkg::ACT_WRITE) &&
                               (reg_q == ppurv_pkg::REG_OAMDATA));
  assign pat_en = accept || pat_we;
  assign nt_en  = accept || nt_we;
  assign pal_en = accept || pal_we;
  assign oam_en = accept || oam_we;

  assign pat_a = clearing ? clr_cnt_q : va14[ppurv_pkg::PAT_AW-1:0];
  assign nt_a  = clearing ? clr_cnt_q[ppurv_pkg::NT_AW-1:0] : nt_addr;
  assign pal_a = clearing ? clr_cnt_q[ppurv_pkg::PAL_AW-1:0] : pal_addr;
  assign oam_a = clearing ? clr_cnt_q[ppurv_pkg::OAM_AW-1:0] : oam_idx_q;
  assign ram_wdata = clearing ? 8'd0 : wdata_q;

  ppurv_ram #(.AW(ppurv_pkg::PAT_AW), .DW(8)) u_pat_ram (
    .clk_i, .en_i(pat_en), .we_i(pat_we), .addr_i(pat_a),
    .wdata_i(ram_wdata), .rdata_o(pat_rdata)
  );

  ppurv_ram #(.AW(ppurv_pkg::NT_AW), .DW(8)) u_nt_ram (
    .clk_i, .en_i(nt_en), .we_i(nt_we), .addr_i(nt_a),
    .wdata_i(ram_wdata), .rdata_o(nt_rdata)
  );

  ppurv_ram #(.AW(ppurv_pkg::PAL_AW), .DW(8)) u_pal_ram (
    .clk_i, .en_i(pal_en), .we_i(pal_we), .addr_i(pal_a),
    .wdata_i(ram_wdata), .rdata_o(pal_rdata)
  );

  ppurv_ram #(.AW(ppurv_pkg::OAM_AW), .DW(8)) u_oam_ram (
    .clk_i, .en_i(oam_en), .we_i(oam_we), .addr_i(oam_a),
    .wdata_i(ram_wdata), .rdata_o(oam_rdata)
  );

  // Next state of the registers and the result beat
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    ctrl_d      = ctrl_q;
    mask_d      = mask_q;
    toggle_d    = toggle_q;
    rbuf_d      = rbuf_q;
    vaddr_d     = vaddr_q;
    taddr_d     = taddr_q;
    finex_d     = finex_q;
    oam_idx_d   = oam_idx_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_data_d  = out_data_q;
    out_clr_d   = out_clr_q;

    unique case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == ppurv_pkg::PAT_AW'(ppurv_pkg::PAT_BYTES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (complete) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          out_data_d  = 8'd0;
          out_clr_d   = 1'b0;
          if (act_q == ppurv_pkg::ACT_READ) begin
            case (reg_q)
              ppurv_pkg::REG_STATUS: begin
                out_data_d = {rs_q, rbuf_q[4:0]};
                out_clr_d  = 1'b1;
                toggle_d   = 1'b0;
              end
              ppurv_pkg::REG_OAMDATA: begin
                out_data_d = oam_rdata;
              end
              ppurv_pkg::REG_DATA: begin
                // Palette reads bypass the delay buffer.
                out_data_d = is_pal ? mem_val : rbuf_q;
                rbuf_d     = mem_val;
                vaddr_d    = vaddr_q + (ctrl_q[2] ? ppurv_pkg::STEP_ROW : ppurv_pkg::STEP_ONE);
              end
              default: begin
                out_data_d = 8'd0;
              end
            endcase
          end else begin
            case (reg_q)
              ppurv_pkg::REG_CTRL: begin
                ctrl_d  = wdata_q;
                taddr_d = {taddr_q[15:12], wdata_q[1:0], taddr_q[9:0]};
              end
              ppurv_pkg::REG_MASK: begin
                mask_d = wdata_q;
              end
              ppurv_pkg::REG_OAMADDR: begin
                oam_idx_d = wdata_q;
              end
              ppurv_pkg::REG_OAMDATA: begin
                oam_idx_d = oam_idx_q + 1'b1;
              end
              ppurv_pkg::REG_SCROLL: begin
                if (!toggle_q) begin
                  finex_d  = wdata_q[2:0];
                  taddr_d  = {taddr_q[15:5], wdata_q[7:3]};
                  toggle_d = 1'b1;
                end else begin
                  taddr_d  = {taddr_q[15], wdata_q[2:0], taddr_q[11:10], wdata_q[7:3],
                              taddr_q[4:0]};
                  toggle_d = 1'b0;
                end
              end
              ppurv_pkg::REG_ADDR: begin
                if (!toggle_q) begin
                  taddr_d  = {2'b00, wdata_q[5:0], taddr_q[7:0]};
                  toggle_d = 1'b1;
                end else begin
                  taddr_d  = {taddr_q[15:8], wdata_q};
                  vaddr_d  = {taddr_q[15:8], wdata_q};
                  toggle_d = 1'b0;
                end
              end
              ppurv_pkg::REG_DATA: begin
                vaddr_d = vaddr_q + (ctrl_q[2] ? ppurv_pkg::STEP_ROW : ppurv_pkg::STEP_ONE);
              end
              default: begin
                ctrl_d = ctrl_q;
              end
            endcase
          end
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // State, registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      ctrl_q      <= 8'd0;
      mask_q      <= 8'd0;
      toggle_q    <= 1'b0;
      rbuf_q      <= 8'd0;
      vaddr_q     <= 16'd0;
      taddr_q     <= 16'd0;
      finex_q     <= 3'd0;
      oam_idx_q   <= 8'd0;
      out_valid_q <= 1'b0;
      out_data_q  <= 8'd0;
      out_clr_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      ctrl_q      <= ctrl_d;
      mask_q      <= mask_d;
      toggle_q    <= toggle_d;
      rbuf_q      <= rbuf_d;
      vaddr_q     <= vaddr_d;
      taddr_q     <= taddr_d;
      finex_q     <= finex_d;
      oam_idx_q   <= oam_idx_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
      out_clr_q   <= out_clr_d;
    end
  end

  // Capture the accepted beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q   <= req_i.action;
      reg_q   <= req_i.reg_index;
      wdata_q <= req_i.write_data;
      rs_q    <= req_i.render_status;
    end
  end

  // The register fields of a result are sampled when the beat is loaded.
  logic [7:0]  out_ctrl_q, out_mask_q;
  logic [15:0] out_vaddr_q, out_taddr_q;
  logic [2:0]  out_finex_q;

  always_ff @(posedge clk_i) begin
    if (complete) begin
      out_ctrl_q  <= ctrl_d;
      out_mask_q  <= mask_d;
      out_vaddr_q <= vaddr_d;
      out_taddr_q <= taddr_d;
      out_finex_q <= finex_d;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.read_data       = out_data_q;
  assign rsp_o.clear_vblank    = out_clr_q;
  assign rsp_o.ctrl_value      = out_ctrl_q;
  assign rsp_o.mask_value      = out_mask_q;
  assign rsp_o.current_address = out_vaddr_q;
  assign rsp_o.scroll_temp     = out_taddr_q;
  assign rsp_o.fine_scroll_x   = out_finex_q;

  // No access is taken during the clearing pass.
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !accept) else $error("access accepted during clearing pass");

  // An accepted access always moves on to the execute step.
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EXEC)) else $error("accept did not enter execute");

  // Completion always leaves a result beat in the output register.
  a_complete_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    complete |=> out_valid_q) else $error("completed access produced no beat");

  // A status read clears the shared write toggle.
  a_status_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (complete && (act_q == ppurv_pkg::ACT_READ) && (reg_q == ppurv_pkg::REG_STATUS))
    |=> !toggle_q) else $error("status read left write toggle set");

  // An OAM data write steps the OAM index by one.
  a_oam_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (complete && (act_q == ppurv_pkg::ACT_WRITE) && (reg_q == ppurv_pkg::REG_OAMDATA))
    |=> (oam_idx_q == $past(oam_idx_q) + 8'd1)) else $error("OAM index did not step");

endmodule
